// File: design/fixed_point_alu_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-point ALU.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_ALU_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FPA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPA_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FPA_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

// File: design/fpa_pkg.sv
// ---------------------------------------------------------------------------
// fpa_pkg
// Operation codes and field widths for the fixed-point ALU.
// ---------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
    localparam int OP_BITS  = 3;
    localparam int OUT_BITS = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4
    } t_op;
endpackage
`default_nettype wire

// File: design/fixed_point_alu_core.sv
// Pipeline: operand stage, WORD_BITS + FRAC_BITS divider stages and an output
// stage; WORD_BITS + FRAC_BITS + 2 register stages in all.
// Throughput: one word per cycle while the output is not stalled; the divider has
// one stage per quotient bit.
// Reset: i_rst_n synchronous, active low; clears all valid bits.
// ---------------------------------------------------------------------------
// fixed_point_alu_core
// Signed fixed-point add, subtract, negate, multiply and divide, pipelined.
// ---------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_core_defines.svh"
module fixed_point_alu_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] operand_a, [63:32] operand_b
    input  wire logic [63:0]                   s_axis_tdata,
    // [2:0] operation
    input  wire logic [fpa_pkg::OP_BITS-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [31:0] result
    output logic [31:0]                        m_axis_tdata,
    // [0] divide_by_zero
    output logic                               m_axis_tuser
);
    import fpa_pkg::*;

    localparam int NB    = WORD_BITS + FRAC_BITS;
    localparam int DEPTH = NB + 2;

    logic w_en;
    logic r_vld [DEPTH];

    // Advance when the output slot is free or being taken
    assign w_en          = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    // Stage 1: decode operands
    logic [OP_BITS-1:0]          r1_op;
    logic signed [WORD_BITS-1:0] r1_a, r1_b;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op <= s_axis_tuser;
            r1_a  <= s_axis_tdata[0 +: WORD_BITS];
            r1_b  <= s_axis_tdata[32 +: WORD_BITS];
        end
    end

    // Stage 2: simple ops, product, divider operands
    logic signed [WORD_BITS-1:0]   r2_simple;
    logic signed [2*WORD_BITS-1:0] r2_prod;
    logic [OP_BITS-1:0]            r2_op;
    logic                          r2_neg, r2_dz;
    logic [NB-1:0]                 n_num;
    logic [WORD_BITS-1:0]          n_den;
    always_comb begin
        n_num = r1_a[WORD_BITS-1] ? NB'(-({{FRAC_BITS{r1_a[WORD_BITS-1]}}, r1_a}
                    <<< FRAC_BITS)) : NB'({{FRAC_BITS{1'b0}}, r1_a} << FRAC_BITS);
        n_den = r1_b[WORD_BITS-1] ? WORD_BITS'(-r1_b) : WORD_BITS'(r1_b);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_op   <= r1_op;
            r2_prod <= r1_a * r1_b;
            r2_neg  <= r1_a[WORD_BITS-1] ^ r1_b[WORD_BITS-1];
            r2_dz   <= (r1_b == '0);
            unique case (r1_op)
                OP_ADD:  r2_simple <= r1_a + r1_b;
                OP_SUB:  r2_simple <= r1_a - r1_b;
                OP_NEG:  r2_simple <= -r1_a;
                default: r2_simple <= '0;
            endcase
        end
    end

    // Divider runs alongside stage 2 onward
    logic [NB-1:0] w_quo;
    fpa_div #(.NUM_BITS(NB), .DEN_BITS(WORD_BITS)) u_div (
        .i_clk (i_clk), .i_en (w_en), .i_num (n_num), .i_den (n_den), .o_quo (w_quo)
    );

    // Delay line for the non-divide result to meet the quotient
    logic signed [WORD_BITS-1:0] r_res [NB-1];
    logic                        r_dz  [NB-1];
    logic                        r_isd [NB-1];
    logic                        r_ng  [NB-1];
    logic signed [WORD_BITS-1:0] n_res0;
    always_comb begin
        unique case (r2_op)
            OP_MUL:  n_res0 = WORD_BITS'(r2_prod >>> FRAC_BITS);
            default: n_res0 = r2_simple;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res[0] <= n_res0;
            r_dz[0]  <= (r2_op == OP_DIV) && r2_dz;
            r_isd[0] <= (r2_op == OP_DIV) && !r2_dz;
            r_ng[0]  <= r2_neg;
            for (int i = 1; i < NB - 1; i++) begin
                r_res[i] <= r_res[i-1];
                r_dz[i]  <= r_dz[i-1];
                r_isd[i] <= r_isd[i-1];
                r_ng[i]  <= r_ng[i-1];
            end
        end
    end

    // Output stage: pick quotient, fix sign, sign-extend
    logic [WORD_BITS-1:0] n_q;
    logic [OUT_BITS-1:0]  r_out;
    logic                 r_odz;
    always_comb begin
        n_q = r_ng[NB-2] ? WORD_BITS'(-w_quo) : WORD_BITS'(w_quo);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odz <= r_dz[NB-2];
            if (r_isd[NB-2]) begin
                r_out <= OUT_BITS'(signed'(n_q));
            end else begin
                r_out <= OUT_BITS'(r_res[NB-2]);
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) r_vld[i] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < DEPTH; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_odz;

    `FPA_ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)), "output word changed while stalled")
    `FPA_ASSERT_IMPL(a_dz_zero, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "divide by zero with nonzero result")
    `FPA_ASSERT_NORST(a_ready, i_clk, (!m_axis_tvalid) |-> s_axis_tready, "not ready with empty output slot")
endmodule
`default_nettype wire

// File: design/fpa_div.sv
// ---------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
// Numerator magnitude, divisor magnitude; signs fixed by caller.
// ---------------------------------------------------------------------------
`default_nettype none
module fpa_div #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic      [NUM_BITS-1:0] o_quo
);
    // Per stage: quotient/remainder shift word, remainder and divisor
    logic [NUM_BITS-1:0] r_q   [NUM_BITS];
    logic [DEN_BITS-1:0] r_rem [NUM_BITS-1];
    logic [DEN_BITS-1:0] r_d   [NUM_BITS-1];

    // One quotient bit per stage
    for (genvar g = 0; g < NUM_BITS; g++) begin : g_stage
        logic [NUM_BITS-1:0] n_qin;
        logic [DEN_BITS-1:0] n_remin;
        logic [DEN_BITS-1:0] n_din;
        logic [DEN_BITS+1:0] n_trial;
        logic [DEN_BITS:0]   n_sh;

        // First stage takes the inputs, later stages the previous registers
        if (g == 0) begin : g_first
            assign n_qin   = i_num;
            assign n_remin = '0;
            assign n_din   = i_den;
        end else begin : g_next
            assign n_qin   = r_q[g-1];
            assign n_remin = r_rem[g-1];
            assign n_din   = r_d[g-1];
        end

        always_comb begin
            n_sh    = {n_remin, n_qin[NUM_BITS-1]};
            n_trial = {1'b0, n_sh} - {2'b00, n_din};
        end

        // Shift in the quotient bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g] <= {n_qin[NUM_BITS-2:0], !n_trial[DEN_BITS+1]};
            end
        end

        // Carry remainder and divisor to the next stage
        if (g < NUM_BITS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[g] <= n_din;
                    if (!n_trial[DEN_BITS+1]) begin
                        r_rem[g] <= n_trial[DEN_BITS-1:0];
                    end else begin
                        r_rem[g] <= n_sh[DEN_BITS-1:0];
                    end
                end
            end
        end
    end

    assign o_quo = r_q[NUM_BITS-1];
endmodule
`default_nettype wire
